FILE: sv/assert_macros.svh
// Assertion macros used by the compositor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define LBSC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define LBSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is asserted.
`define LBSC_ASSERT_AFTER_RESET(label, cond, msg) \
  label: assert property (@(posedge clk) rst |=> (cond)) else $error(msg);

`endif

FILE: sv/lbsc_pkg.sv
// Types, constants, sprite tables and helper functions of the bitplane compositor.
package lbsc_pkg;

  localparam int PLANE_ROWS = 16;
  localparam int PLANE_COLS = 16;
  localparam int ROW_W = $clog2(PLANE_ROWS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(PLANE_ROWS - 1);

  localparam int IN_W = 24;
  localparam int OUT_W = 48;

  localparam logic [7:0] NULL_VALUE = 8'd200;
  localparam logic [7:0] FULL_PERCENT = 8'd100;

  typedef enum logic [2:0] {
    CMD_MAXTEMP = 3'd0,
    CMD_CURTEMP = 3'd1,
    CMD_PRECIP  = 3'd2,
    CMD_MOON    = 3'd3,
    CMD_WEEKDAY = 3'd4,
    CMD_PATTERN = 3'd5,
    CMD_READ    = 3'd6,
    CMD_CLEAR   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    COL_RED    = 3'd0,
    COL_GREEN  = 3'd1,
    COL_BLUE   = 3'd2,
    COL_YELLOW = 3'd3,
    COL_CYAN   = 3'd4,
    COL_PURPLE = 3'd5,
    COL_WHITE  = 3'd6,
    COL_ALTRED = 3'd7
  } color_t;

  localparam logic [2:0] DIGIT_FONT [10][5] = '{
    '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7}, '{3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
    '{3'd7, 3'd1, 3'd7, 3'd4, 3'd7}, '{3'd7, 3'd1, 3'd3, 3'd1, 3'd7},
    '{3'd5, 3'd5, 3'd7, 3'd1, 3'd1}, '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
    '{3'd7, 3'd4, 3'd7, 3'd5, 3'd7}, '{3'd7, 3'd1, 3'd2, 3'd4, 3'd4},
    '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7}, '{3'd7, 3'd5, 3'd7, 3'd1, 3'd7}
  };

  localparam logic [6:0] DAY_GLYPH [7][5] = '{
    '{7'h70, 7'h40, 7'h75, 7'h15, 7'h77}, '{7'h22, 7'h36, 7'h2A, 7'h22, 7'h22},
    '{7'h38, 7'h10, 7'h15, 7'h15, 7'h17}, '{7'h22, 7'h22, 7'h2A, 7'h36, 7'h22},
    '{7'h74, 7'h24, 7'h27, 7'h25, 7'h25}, '{7'h0E, 7'h08, 7'h0C, 7'h08, 7'h08},
    '{7'h72, 7'h45, 7'h77, 7'h15, 7'h75}
  };

  localparam logic [6:0] RAIN_LINE [2] = '{7'd42, 7'd85};
  localparam logic [6:0] TOP_LINE = 7'd127;
  localparam logic [3:0] MOON_FULL [4] = '{4'd6, 4'd15, 4'd15, 4'd6};
  localparam logic [3:0] MOON_NEAR [4] = '{4'd6, 4'd7, 4'd7, 4'd6};

  // Controller to datapath commands.
  typedef struct packed {
    logic             load;
    logic             wr;
    logic             capture;
    logic [ROW_W-1:0] row;
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
  } sts_t;

  // Plane mask of a color: bit 0 red, bit 1 green, bit 2 blue.
  function automatic logic [2:0] color_planes(color_t c);
    logic [2:0] m;
    unique case (c)
      COL_RED:    m = 3'b001;
      COL_GREEN:  m = 3'b010;
      COL_BLUE:   m = 3'b100;
      COL_YELLOW: m = 3'b011;
      COL_CYAN:   m = 3'b110;
      COL_PURPLE: m = 3'b101;
      COL_WHITE:  m = 3'b111;
      COL_ALTRED: m = 3'b001;
      default:    m = 3'b001;
    endcase
    return m;
  endfunction

  // One row of a two-digit number or of the null mark, before the column shift.
  function automatic logic [7:0] num_bits(logic null_f, logic [3:0] tens,
                                          logic [3:0] ones, logic [ROW_W-1:0] off);
    logic [7:0] b;
    b = '0;
    if (off < ROW_W'(5)) begin
      if (null_f) begin
        b = 8'(9'd2 << off[2:0]);
      end else begin
        b = {1'b0, DIGIT_FONT[tens][off[2:0]], 1'b0, DIGIT_FONT[ones][off[2:0]]};
      end
    end
    return b;
  endfunction

endpackage

FILE: sv/lbsc_ctrl.sv
// Command sequencer of the compositor: accepts words and steps the row sweep.
module lbsc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  lbsc_pkg::cmd_t       in_func,
  output logic                 in_ready,
  output lbsc_pkg::ctl_t       ctl,
  input  lbsc_pkg::sts_t       sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ
  } state_t;

  state_t                     state;
  logic [lbsc_pkg::ROW_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            if (in_func == lbsc_pkg::CMD_READ) begin
              state <= ST_READ;
            end else begin
              state <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (cnt == lbsc_pkg::ROW_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (sts.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready    = (state == ST_IDLE);
  assign ctl.load    = in_valid && (state == ST_IDLE);
  assign ctl.wr      = (state == ST_SWEEP);
  assign ctl.capture = (state == ST_READ) && sts.out_free;
  assign ctl.row     = cnt;

endmodule

FILE: sv/lbsc_datapath.sv
// Bitplane storage, sprite row generation and the result register.
module lbsc_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lbsc_pkg::IN_W-1:0] in_word,
  input  lbsc_pkg::ctl_t            ctl,
  output lbsc_pkg::sts_t            sts,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [15:0]               red_row,
  output logic [15:0]               green_row,
  output logic [15:0]               blue_row
);

  localparam int RW = lbsc_pkg::ROW_W;

  logic [lbsc_pkg::PLANE_COLS-1:0] red_plane   [lbsc_pkg::PLANE_ROWS];
  logic [lbsc_pkg::PLANE_COLS-1:0] green_plane [lbsc_pkg::PLANE_ROWS];
  logic [lbsc_pkg::PLANE_COLS-1:0] blue_plane  [lbsc_pkg::PLANE_ROWS];

  lbsc_pkg::cmd_t  func_q;
  logic [2:0]      cm_q;
  logic [7:0]      value_q;
  logic [RW-1:0]   rsel_q;
  logic            null_q;
  logic [3:0]      tens_q;
  logic [3:0]      ones_q;

  logic [7:0]      v_in;
  logic [7:0]      v_mod;
  logic [15:0]     v_prod;
  logic [3:0]      v_tens;
  logic [3:0]      v_ones;

  logic [RW-1:0]   r;
  logic [RW-1:0]   addr;
  logic [15:0]     sel_m;
  logic [15:0]     all_m;
  logic [15:0]     red_x;
  logic [15:0]     grn_x;
  logic [15:0]     blu_x;
  logic [15:0]     red_m;
  logic [15:0]     grn_m;
  logic [15:0]     blu_m;
  logic [RW-1:0]   off;
  logic            clr;

  // Split the value modulo 100 into decimal digits.
  always_comb begin
    v_in = in_word[13:6];
    if (v_in >= 8'd200) begin
      v_mod = v_in - 8'd200;
    end else if (v_in >= 8'd100) begin
      v_mod = v_in - 8'd100;
    end else begin
      v_mod = v_in;
    end
    v_prod = 16'(v_mod) * 16'd205;
    v_tens = v_prod[14:11];
    v_ones = 4'(v_mod - 8'(v_tens) * 8'd10);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      func_q  <= lbsc_pkg::cmd_t'(in_word[2:0]);
      cm_q    <= lbsc_pkg::color_planes(lbsc_pkg::color_t'(in_word[5:3]));
      value_q <= v_in;
      rsel_q  <= in_word[17:14];
      null_q  <= (v_in == lbsc_pkg::NULL_VALUE);
      tens_q  <= v_tens;
      ones_q  <= v_ones;
    end
  end

  assign r    = ctl.row;
  assign addr = ctl.capture ? rsel_q : r;
  assign clr  = (func_q == lbsc_pkg::CMD_CLEAR);

  // Sprite bits that land on plane row r for the command held.
  always_comb begin
    sel_m = '0;
    all_m = '0;
    red_x = '0;
    grn_x = '0;
    blu_x = '0;
    off   = '0;
    case (func_q)
      lbsc_pkg::CMD_MAXTEMP: begin
        if (r == RW'(0)) begin
          sel_m = 16'(lbsc_pkg::TOP_LINE);
        end
        sel_m = sel_m | 16'(lbsc_pkg::num_bits(null_q, tens_q, ones_q, r - RW'(2)));
      end
      lbsc_pkg::CMD_CURTEMP: begin
        sel_m = 16'(lbsc_pkg::num_bits(null_q, tens_q, ones_q, r - RW'(10)));
      end
      lbsc_pkg::CMD_PRECIP: begin
        if (value_q == lbsc_pkg::FULL_PERCENT) begin
          if (r == RW'(4) || r == RW'(7)) begin
            sel_m = 16'(lbsc_pkg::RAIN_LINE[0]) << 9;
          end else if (r == RW'(5) || r == RW'(8)) begin
            sel_m = 16'(lbsc_pkg::RAIN_LINE[1]) << 9;
          end
        end else if (value_q < lbsc_pkg::FULL_PERCENT) begin
          sel_m = 16'(lbsc_pkg::num_bits(null_q, tens_q, ones_q, r - RW'(4))) << 9;
          if (r == RW'(1)) begin
            sel_m = sel_m | (16'(lbsc_pkg::RAIN_LINE[0]) << 9);
          end else if (r == RW'(2)) begin
            sel_m = sel_m | (16'(lbsc_pkg::RAIN_LINE[1]) << 9);
          end
        end
      end
      lbsc_pkg::CMD_MOON: begin
        off = r - RW'(11);
        if (off < RW'(4)) begin
          if (value_q == 8'd2) begin
            all_m = 16'(lbsc_pkg::MOON_FULL[off[1:0]]) << 10;
          end else if (value_q == 8'd1) begin
            all_m = 16'(lbsc_pkg::MOON_NEAR[off[1:0]]) << 10;
          end
        end
      end
      lbsc_pkg::CMD_WEEKDAY: begin
        off = r - RW'(10);
        if (value_q < 8'd7 && off < RW'(5)) begin
          grn_x = 16'(lbsc_pkg::DAY_GLYPH[value_q[2:0]][off[2:0]]);
        end
      end
      lbsc_pkg::CMD_PATTERN: begin
        case (r[RW-1:RW-2])
          2'd0: red_x = 16'd1;
          2'd1: grn_x = 16'd1;
          2'd2: blu_x = 16'd1;
          default: begin
            red_x = 16'd1;
            grn_x = 16'd2;
            blu_x = 16'd4;
          end
        endcase
      end
      default: begin
        sel_m = '0;
      end
    endcase
    red_m = (cm_q[0] ? sel_m : 16'd0) | all_m | red_x;
    grn_m = (cm_q[1] ? sel_m : 16'd0) | all_m | grn_x;
    blu_m = (cm_q[2] ? sel_m : 16'd0) | all_m | blu_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lbsc_pkg::PLANE_ROWS; i++) begin
        red_plane[i]   <= '0;
        green_plane[i] <= '0;
        blue_plane[i]  <= '0;
      end
    end else if (ctl.wr) begin
      if (clr) begin
        red_plane[addr]   <= '0;
        green_plane[addr] <= '0;
        blue_plane[addr]  <= '0;
      end else begin
        red_plane[addr]   <= red_plane[addr] | red_m;
        green_plane[addr] <= green_plane[addr] | grn_m;
        blue_plane[addr]  <= blue_plane[addr] | blu_m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.capture) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      red_row   <= red_plane[addr];
      green_row <= green_plane[addr];
      blue_row  <= blue_plane[addr];
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

FILE: sv/led_bitplane_sprite_compositor_top.sv
// Top level of the LED bitplane sprite compositor.
//
// Commands arrive as words on the s_ channel; each word carries a command,
// a color, a value and a row index. Draw, pattern and clear commands update
// three 16x16 bitplanes and return nothing. A read command returns one word
// on the m_ channel holding the selected row of the red, green and blue planes.
// A draw or clear command is accepted while the block is idle; the datapath
// then sweeps all 16 plane rows and updates one row of every plane in each
// cycle. A read command is accepted while idle; the selected row word is
// registered once the output register is free, and the block then returns
// to idle and can accept the next word.
// s_tready is low while a command is in progress. When the receiver stalls,
// the result waits in the output register and further commands are still
// accepted; a second read waits until the first result is taken.
// Reset clears all three planes at once and leaves the block idle with no
// result pending.
module led_bitplane_sprite_compositor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // func[2:0], color[5:3], value[13:6], row_select[17:14], zero[23:18]
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // red_row[15:0], green_row[31:16], blue_row[47:32]
  output logic [47:0] m_tdata
);

  `include "assert_macros.svh"

  lbsc_pkg::ctl_t ctl;
  lbsc_pkg::sts_t sts;
  lbsc_pkg::cmd_t in_func;
  logic [15:0]    red_row;
  logic [15:0]    green_row;
  logic [15:0]    blue_row;

  assign in_func = lbsc_pkg::cmd_t'(s_tdata[2:0]);

  lbsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_func  (in_func),
    .in_ready (s_tready),
    .ctl      (ctl),
    .sts      (sts)
  );

  lbsc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (s_tdata),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .red_row   (red_row),
    .green_row (green_row),
    .blue_row  (blue_row)
  );

  assign m_tdata = {blue_row, green_row, red_row};

  `LBSC_ASSERT_ALWAYS(a_no_accept_in_sweep, !(s_tready && ctl.wr), "word accepted during sweep")
  `LBSC_ASSERT_ALWAYS(a_capture_when_free, !ctl.capture || !m_tvalid || m_tready, "result overwritten")
  `LBSC_ASSERT_NEXT(a_sweep_starts, s_tvalid && s_tready && in_func != lbsc_pkg::CMD_READ, ctl.wr && ctl.row == '0, "sweep did not start at row zero")
  `LBSC_ASSERT_AFTER_RESET(a_reset_idle, s_tready && !m_tvalid, "block not idle after reset")

endmodule
